// ===== rtl/core/life_like_automaton_with_aging_core_defines.svh =====
// Assertion macros shared by the checker of the life-like automaton core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LIFE_LIKE_AUTOMATON_WITH_AGING_CORE_DEFINES_SVH
`define LIFE_LIKE_AUTOMATON_WITH_AGING_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define LLAA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LLAA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/llaa_pkg.sv =====
// Package of the life-like automaton core: function codes, states, register
// indexes, reset values and the window control struct. Depends on nothing.
`default_nettype none

package llaa_pkg;

    typedef enum logic [2:0] {
        FUNC_WR_ALIVE = 3'd0,
        FUNC_WR_AGE   = 3'd1,
        FUNC_CLEAR    = 3'd2,
        FUNC_ADVANCE  = 3'd3,
        FUNC_READ     = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    localparam logic [1:0] CFG_BIRTH   = 2'd0;
    localparam logic [1:0] CFG_SURVIVE = 2'd1;
    localparam logic [1:0] CFG_MAX_AGE = 2'd2;

    localparam logic [8:0] BIRTH_RESET   = 9'd8;
    localparam logic [8:0] SURVIVE_RESET = 9'd12;
    localparam logic [7:0] MAX_AGE_RESET = 8'd16;

    typedef struct packed {
        logic clear;
        logic shift;
        logic in_grid;
    } win_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/llaa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module llaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/llaa_window.sv =====
// Neighborhood window and rule unit: a shift line of alive bits spanning two
// rows plus three cells, and the birth, survival and aging rule for its center.
// Depends on llaa_pkg.
`default_nettype none

module llaa_window #(
    parameter int GRID_COLS = 64,
    parameter int AGE_BITS  = 8
) (
    input  logic                         clk,
    input  llaa_pkg::win_ctl_t           ctl,
    input  logic                         alive_rdata,
    input  logic [$clog2(GRID_COLS)-1:0] col,
    input  logic [AGE_BITS-1:0]          age_old,
    input  logic [8:0]                   birth_mask,
    input  logic [8:0]                   survive_mask,
    input  logic [7:0]                   max_age,
    output logic                         new_alive,
    output logic [AGE_BITS-1:0]          new_age
);

    localparam int C      = GRID_COLS;
    localparam int SH_LEN = 2 * GRID_COLS + 3;
    localparam int COL_W  = $clog2(GRID_COLS);

    logic [SH_LEN-1:0]     sh_reg;
    logic [SH_LEN-1:0]     sh_next;
    logic                  left_ok;
    logic                  right_ok;
    logic [7:0]            nbr;
    logic [3:0]            count;
    logic                  center;
    logic [AGE_BITS+7:0]   max_ext;
    logic [AGE_BITS+7:0]   mask_ext;
    logic [AGE_BITS-1:0]   limit;

    always_comb
    begin
        if (ctl.clear)
        begin
            sh_next = '0;
        end
        else if (ctl.shift)
        begin
            sh_next = {sh_reg[SH_LEN-2:0], ctl.in_grid & alive_rdata};
        end
        else
        begin
            sh_next = sh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    assign left_ok  = (col != '0);
    assign right_ok = (col != COL_W'(GRID_COLS - 1));
    assign center   = sh_reg[C+1];

    assign nbr = {
        sh_reg[2*C+2] & left_ok,
        sh_reg[2*C+1],
        sh_reg[2*C]   & right_ok,
        sh_reg[C+2]   & left_ok,
        sh_reg[C]     & right_ok,
        sh_reg[2]     & left_ok,
        sh_reg[1],
        sh_reg[0]     & right_ok
    };

    always_comb
    begin
        count = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            count = count + {3'd0, nbr[i]};
        end
    end

    assign max_ext  = (AGE_BITS+8)'(max_age);
    assign mask_ext = (AGE_BITS+8)'({AGE_BITS{1'b1}});
    assign limit    = (max_ext < mask_ext) ? max_ext[AGE_BITS-1:0] : {AGE_BITS{1'b1}};

    always_comb
    begin
        new_alive = center;
        new_age   = age_old;
        if (!center)
        begin
            if (birth_mask[count])
            begin
                new_alive = 1'b1;
                new_age   = '0;
            end
            else if (age_old < limit)
            begin
                new_age = age_old + AGE_BITS'(1);
            end
        end
        else
        begin
            new_alive = survive_mask[count];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/life_like_automaton_with_aging_core.sv =====
// Top level of the life-like automaton core with per-cell aging: sequencer,
// configuration registers and the two cell stores. Depends on llaa_pkg,
// llaa_ram and llaa_window.
//
// Channel   | Handshake                 | Payload
// ----------+---------------------------+---------------------------------------
// request   | start, busy               | func, row, col, new_alive, new_age
// result    | done (one-cycle strobe)   | alive, age
// config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// Writes and unused codes leave busy low; the result strobe follows the accept edge.
// A read holds busy high in ST_READ, for the registered read of the stores.
// A clear holds busy high in ST_CLEAR, one alive entry written per cycle.
// An advance holds busy high through ST_SCAN and ST_DRAIN while the single read
// port of the alive store sweeps every cell once.
// After reset a clearing pass over every cell holds busy high; config is taken.
// The receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none

module life_like_automaton_with_aging_core #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64,
    parameter int AGE_BITS  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] func,
    input  logic [5:0] row,
    input  logic [5:0] col,
    input  logic       new_alive,
    input  logic [7:0] new_age,
    output logic       done,
    output logic       alive,
    output logic [7:0] age,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    localparam int CELLS     = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int SCAN_LAST = CELLS + GRID_COLS;
    localparam int CNT_W     = $clog2(SCAN_LAST + 1);

    llaa_pkg::state_t state_reg;
    llaa_pkg::state_t state_next;

    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                s1_vld_reg;
    logic                s1_in_reg;
    logic                s1_ctr_reg;
    logic                s2_vld_reg;
    logic [ADDR_W-1:0]   s2_idx_reg;
    logic [COL_W-1:0]    s2_col_reg;
    logic [ADDR_W-1:0]   cen_idx_reg;
    logic [ADDR_W-1:0]   cen_idx_next;
    logic [COL_W-1:0]    cen_col_reg;
    logic [COL_W-1:0]    cen_col_next;
    logic                rd_inside_reg;
    logic                rd_inside_next;
    logic [8:0]          birth_reg;
    logic [8:0]          survive_reg;
    logic [7:0]          max_age_reg;
    logic                done_reg;
    logic                done_next;
    logic                alive_reg;
    logic                alive_next;
    logic [7:0]          age_reg;
    logic [7:0]          age_next;

    logic                accept;
    logic                req_inside;
    logic [31:0]         req_idx_wide;
    logic [ADDR_W-1:0]   req_idx;
    logic                stage1_ctr;

    logic                alive_we;
    logic [ADDR_W-1:0]   alive_waddr;
    logic                alive_wdata;
    logic                alive_re;
    logic [ADDR_W-1:0]   alive_raddr;
    logic                alive_rdata;
    logic                age_we;
    logic [ADDR_W-1:0]   age_waddr;
    logic [AGE_BITS-1:0] age_wdata;
    logic                age_re;
    logic [ADDR_W-1:0]   age_raddr;
    logic [AGE_BITS-1:0] age_rdata;

    logic [AGE_BITS+7:0] wr_age_ext;
    logic [AGE_BITS+7:0] rd_age_ext;
    llaa_pkg::win_ctl_t  win_ctl;
    logic                win_alive;
    logic [AGE_BITS-1:0] win_age;

    assign busy      = (state_reg != llaa_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign alive     = alive_reg;
    assign age       = age_reg;

    assign req_inside   = (32'(row) < GRID_ROWS) && (32'(col) < GRID_COLS);
    assign req_idx_wide = 32'(row) * 32'(GRID_COLS) + 32'(col);
    assign req_idx      = req_idx_wide[ADDR_W-1:0];
    assign wr_age_ext   = (AGE_BITS+8)'(new_age);
    assign rd_age_ext   = (AGE_BITS+8)'(age_rdata);
    assign stage1_ctr   = s1_vld_reg && s1_ctr_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            llaa_pkg::ST_INIT:
            begin
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = llaa_pkg::ST_IDLE;
                end
            end
            llaa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (llaa_pkg::func_t'(func))
                        llaa_pkg::FUNC_CLEAR:   state_next = llaa_pkg::ST_CLEAR;
                        llaa_pkg::FUNC_ADVANCE: state_next = llaa_pkg::ST_SCAN;
                        llaa_pkg::FUNC_READ:    state_next = llaa_pkg::ST_READ;
                        default:                state_next = llaa_pkg::ST_IDLE;
                    endcase
                end
            end
            llaa_pkg::ST_READ:
            begin
                state_next = llaa_pkg::ST_IDLE;
            end
            llaa_pkg::ST_CLEAR:
            begin
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = llaa_pkg::ST_IDLE;
                end
            end
            llaa_pkg::ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(SCAN_LAST))
                begin
                    state_next = llaa_pkg::ST_DRAIN;
                end
            end
            llaa_pkg::ST_DRAIN:
            begin
                if (!s1_vld_reg)
                begin
                    state_next = llaa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = llaa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        rd_inside_next = rd_inside_reg;
        done_next      = 1'b0;
        alive_next     = 1'b0;
        age_next       = 8'd0;
        alive_we       = 1'b0;
        alive_waddr    = req_idx;
        alive_wdata    = new_alive;
        alive_re       = 1'b0;
        alive_raddr    = req_idx;
        age_we         = 1'b0;
        age_waddr      = req_idx;
        age_wdata      = wr_age_ext[AGE_BITS-1:0];
        age_re         = 1'b0;
        age_raddr      = req_idx;
        win_ctl        = '{clear: 1'b0, shift: s1_vld_reg, in_grid: s1_in_reg};
        case (state_reg)
            llaa_pkg::ST_INIT:
            begin
                alive_we    = 1'b1;
                alive_waddr = cnt_reg[ADDR_W-1:0];
                alive_wdata = 1'b0;
                age_we      = 1'b1;
                age_waddr   = cnt_reg[ADDR_W-1:0];
                age_wdata   = '0;
                cnt_next    = cnt_reg + CNT_W'(1);
            end
            llaa_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    case (llaa_pkg::func_t'(func))
                        llaa_pkg::FUNC_WR_ALIVE:
                        begin
                            alive_we  = req_inside;
                            done_next = 1'b1;
                        end
                        llaa_pkg::FUNC_WR_AGE:
                        begin
                            age_we    = req_inside;
                            done_next = 1'b1;
                        end
                        llaa_pkg::FUNC_CLEAR:
                        begin
                        end
                        llaa_pkg::FUNC_ADVANCE:
                        begin
                            win_ctl.clear = 1'b1;
                        end
                        llaa_pkg::FUNC_READ:
                        begin
                            alive_re       = 1'b1;
                            age_re         = 1'b1;
                            rd_inside_next = req_inside;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            llaa_pkg::ST_READ:
            begin
                done_next  = 1'b1;
                alive_next = rd_inside_reg & alive_rdata;
                age_next   = rd_inside_reg ? rd_age_ext[7:0] : 8'd0;
            end
            llaa_pkg::ST_CLEAR:
            begin
                alive_we    = 1'b1;
                alive_waddr = cnt_reg[ADDR_W-1:0];
                alive_wdata = 1'b0;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    done_next = 1'b1;
                end
            end
            llaa_pkg::ST_SCAN:
            begin
                alive_re    = (cnt_reg < CNT_W'(CELLS));
                alive_raddr = cnt_reg[ADDR_W-1:0];
                cnt_next    = cnt_reg + CNT_W'(1);
            end
            llaa_pkg::ST_DRAIN:
            begin
                if (!s1_vld_reg)
                begin
                    done_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (stage1_ctr)
        begin
            age_re    = 1'b1;
            age_raddr = cen_idx_reg;
        end
        if (s2_vld_reg)
        begin
            alive_we    = 1'b1;
            alive_waddr = s2_idx_reg;
            alive_wdata = win_alive;
            age_we      = 1'b1;
            age_waddr   = s2_idx_reg;
            age_wdata   = win_age;
        end
    end

    always_comb
    begin
        cen_idx_next = cen_idx_reg;
        cen_col_next = cen_col_reg;
        if (win_ctl.clear)
        begin
            cen_idx_next = '0;
            cen_col_next = '0;
        end
        else if (stage1_ctr)
        begin
            cen_idx_next = cen_idx_reg + ADDR_W'(1);
            if (cen_col_reg == COL_W'(GRID_COLS - 1))
            begin
                cen_col_next = '0;
            end
            else
            begin
                cen_col_next = cen_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= llaa_pkg::ST_INIT;
            cnt_reg       <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            done_reg      <= 1'b0;
            rd_inside_reg <= 1'b0;
            cen_idx_reg   <= '0;
            cen_col_reg   <= '0;
            birth_reg     <= llaa_pkg::BIRTH_RESET;
            survive_reg   <= llaa_pkg::SURVIVE_RESET;
            max_age_reg   <= llaa_pkg::MAX_AGE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            s1_vld_reg    <= (state_reg == llaa_pkg::ST_SCAN);
            s2_vld_reg    <= stage1_ctr;
            done_reg      <= done_next;
            rd_inside_reg <= rd_inside_next;
            cen_idx_reg   <= cen_idx_next;
            cen_col_reg   <= cen_col_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    llaa_pkg::CFG_BIRTH:   birth_reg   <= cfg_data;
                    llaa_pkg::CFG_SURVIVE: survive_reg <= cfg_data;
                    llaa_pkg::CFG_MAX_AGE: max_age_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_in_reg  <= (cnt_reg < CNT_W'(CELLS));
        s1_ctr_reg <= (cnt_reg >= CNT_W'(GRID_COLS + 1));
        s2_idx_reg <= cen_idx_reg;
        s2_col_reg <= cen_col_reg;
        alive_reg  <= alive_next;
        age_reg    <= age_next;
    end

    llaa_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_alive_ram (
        .clk   (clk),
        .we    (alive_we),
        .waddr (alive_waddr),
        .wdata (alive_wdata),
        .re    (alive_re),
        .raddr (alive_raddr),
        .rdata (alive_rdata)
    );

    llaa_ram #(
        .WIDTH (AGE_BITS),
        .DEPTH (CELLS)
    ) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .re    (age_re),
        .raddr (age_raddr),
        .rdata (age_rdata)
    );

    llaa_window #(
        .GRID_COLS (GRID_COLS),
        .AGE_BITS  (AGE_BITS)
    ) u_window (
        .clk          (clk),
        .ctl          (win_ctl),
        .alive_rdata  (alive_rdata),
        .col          (s2_col_reg),
        .age_old      (age_rdata),
        .birth_mask   (birth_reg),
        .survive_mask (survive_reg),
        .max_age      (max_age_reg),
        .new_alive    (win_alive),
        .new_age      (win_age)
    );

endmodule

`default_nettype wire

// ===== rtl/core/llaa_checker.sv =====
// Port-level checker of the life-like automaton core and its bind statement.
// Depends on llaa_pkg and life_like_automaton_with_aging_core_defines.svh.
`default_nettype none

`include "life_like_automaton_with_aging_core_defines.svh"

module llaa_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [2:0] func,
    input wire logic       done,
    input wire logic       alive,
    input wire logic [7:0] age
);

    // A request that is neither a clear, an advance nor a read answers zero next cycle.
    `LLAA_ASSERT_NEXT(a_quick_result, start && !busy && func != llaa_pkg::FUNC_CLEAR && func != llaa_pkg::FUNC_ADVANCE && func != llaa_pkg::FUNC_READ, done && !alive && age == 8'd0, "quick request gave no zero result")

    `LLAA_ASSERT_NEXT(a_read_timing, start && !busy && func == llaa_pkg::FUNC_READ, busy && !done ##1 done && !busy, "read result not two cycles after request")

    `LLAA_ASSERT_NEXT(a_long_busy, start && !busy && (func == llaa_pkg::FUNC_CLEAR || func == llaa_pkg::FUNC_ADVANCE), busy && !done, "clear or advance did not hold busy")

    `LLAA_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")

endmodule

bind life_like_automaton_with_aging_core llaa_checker u_llaa_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .func  (func),
    .done  (done),
    .alive (alive),
    .age   (age)
);

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for life_like_automaton_with_aging_core: directed and random requests checked
// against a cell-grid predictor kept in the bench. Depends on llaa_pkg and the core RTL.
`default_nettype none

module tb;
    import llaa_pkg::*;

    localparam int ROWS = 64;
    localparam int COLS = 64;
    localparam int CELLS = ROWS * COLS;
    localparam int STALL_LIMIT = 25000;
    localparam int MAX_REPORTS = 10;

    localparam logic [2:0] FUNC_SPARE_A = 3'd5;
    localparam logic [2:0] FUNC_SPARE_B = 3'd6;
    localparam logic [2:0] FUNC_SPARE_C = 3'd7;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [2:0] func;
        logic [5:0] row;
        logic [5:0] col;
        logic       new_alive;
        logic [7:0] new_age;
    } cell_request_t;

    typedef struct packed {
        logic       alive;
        logic [7:0] age;
    } cell_view_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [2:0] func;
    logic [5:0] row;
    logic [5:0] col;
    logic       new_alive;
    logic [7:0] new_age;
    logic       done;
    logic       alive;
    logic [7:0] age;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    life_like_automaton_with_aging_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .row       (row),
        .col       (col),
        .new_alive (new_alive),
        .new_age   (new_age),
        .done      (done),
        .alive     (alive),
        .age       (age),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bit         grid_alive [CELLS];
    logic [7:0] grid_age [CELLS];
    bit         next_alive [CELLS];
    logic [7:0] next_age [CELLS];
    logic [8:0] birth_rule;
    logic [8:0] survive_rule;
    logic [7:0] age_limit;

    cell_view_t expected_cells[$];
    cell_view_t oldest_cell;
    int         mismatches = 0;
    int         idle_cycles = 0;
    bit         no_gaps = 1'b0;

    function automatic int live_neighbors(int r, int c);
        int n;
        int rr;
        int cc;
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                rr = r + dr;
                cc = c + dc;
                if ((dr != 0 || dc != 0) && rr >= 0 && rr < ROWS && cc >= 0 && cc < COLS)
                begin
                    n += grid_alive[rr * COLS + cc];
                end
            end
        end
        return n;
    endfunction

    function automatic void step_generation();
        int n;
        int idx;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                idx = r * COLS + c;
                n = live_neighbors(r, c);
                next_alive[idx] = grid_alive[idx];
                next_age[idx] = grid_age[idx];
                if (!grid_alive[idx])
                begin
                    if (birth_rule[n])
                    begin
                        next_alive[idx] = 1'b1;
                        next_age[idx] = 8'd0;
                    end
                    else if (grid_age[idx] < age_limit)
                    begin
                        next_age[idx] = grid_age[idx] + 8'd1;
                    end
                end
                else
                begin
                    next_alive[idx] = survive_rule[n];
                end
            end
        end
        grid_alive = next_alive;
        grid_age = next_age;
    endfunction

    function automatic cell_view_t apply_request(cell_request_t q);
        cell_view_t view;
        int idx;
        view = '0;
        idx = int'(q.row) * COLS + int'(q.col);
        case (q.func)
            FUNC_WR_ALIVE: grid_alive[idx] = q.new_alive;
            FUNC_WR_AGE:   grid_age[idx] = q.new_age;
            FUNC_CLEAR:
            begin
                foreach (grid_alive[i])
                begin
                    grid_alive[i] = 1'b0;
                end
            end
            FUNC_ADVANCE:  step_generation();
            FUNC_READ:
            begin
                view.alive = grid_alive[idx];
                view.age = grid_age[idx];
            end
            default: ;
        endcase
        return view;
    endfunction

    function automatic cell_request_t mk(logic [2:0] f, logic [5:0] r, logic [5:0] c,
                                         logic na, logic [7:0] ag);
        cell_request_t q;
        q.func = f;
        q.row = r;
        q.col = c;
        q.new_alive = na;
        q.new_age = ag;
        return q;
    endfunction

    function automatic void note_mismatch(string what, cell_view_t want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("mismatch (%s): expected alive %0d age %0d, got alive %0d age %0d",
                     what, want.alive, want.age, alive, age);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_cells.size() == 0)
            begin
                note_mismatch("no request pending", '0);
            end
            else
            begin
                oldest_cell = expected_cells.pop_front();
                if (alive !== oldest_cell.alive || age !== oldest_cell.age)
                begin
                    note_mismatch("cell view", oldest_cell);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic send_request(input cell_request_t q);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 99) < 28)
        begin
            gap = $urandom_range(1, 2);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        func = q.func;
        row = q.row;
        col = q.col;
        new_alive = q.new_alive;
        new_age = q.new_age;
        do @(posedge clk); while (busy);
        expected_cells.push_back(apply_request(q));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (expected_cells.size() != 0 || busy)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [8:0] data);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BIRTH:   birth_rule = data;
            CFG_SURVIVE: survive_rule = data;
            CFG_MAX_AGE: age_limit = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_rules(input logic [8:0] b, input logic [8:0] s, input logic [8:0] m);
        write_register(CFG_BIRTH, b);
        write_register(CFG_SURVIVE, s);
        write_register(CFG_MAX_AGE, m);
    endtask

    function automatic logic [5:0] near(logic [5:0] ctr);
        int v;
        v = int'(ctr) + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 63)
        begin
            v = 63;
        end
        return v[5:0];
    endfunction

    function automatic logic [5:0] pick_center();
        if ($urandom_range(0, 99) < 30)
        begin
            return ($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0;
        end
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic test_after_reset();
        send_request(mk(FUNC_READ, 6'd0, 6'd0, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd63, 6'd63, 1'b1, 8'hFF));
    endtask

    task automatic test_writes_and_spare_codes();
        send_request(mk(FUNC_WR_ALIVE, 6'd0, 6'd0, 1'b1, 8'hFF));
        send_request(mk(FUNC_WR_ALIVE, 6'd63, 6'd63, 1'b1, 8'h00));
        send_request(mk(FUNC_WR_AGE, 6'd0, 6'd63, 1'b0, 8'd255));
        send_request(mk(FUNC_WR_AGE, 6'd63, 6'd0, 1'b1, 8'd0));
        send_request(mk(FUNC_READ, 6'd0, 6'd0, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd0, 6'd63, 1'b0, 8'd0));
        send_request(mk(FUNC_SPARE_A, 6'd63, 6'd63, 1'b1, 8'hFF));
        send_request(mk(FUNC_SPARE_B, 6'd0, 6'd0, 1'b1, 8'hAA));
        send_request(mk(FUNC_SPARE_C, 6'd63, 6'd0, 1'b0, 8'h55));
    endtask

    task automatic test_clear_keeps_ages();
        send_request(mk(FUNC_WR_AGE, 6'd63, 6'd63, 1'b0, 8'd77));
        send_request(mk(FUNC_CLEAR, 6'd0, 6'd0, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd63, 6'd63, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd0, 6'd63, 1'b0, 8'd0));
    endtask

    // A corner L shape in the top-right corner; nothing may wrap to the far edges.
    task automatic test_edge_generation();
        send_request(mk(FUNC_WR_ALIVE, 6'd0, 6'd62, 1'b1, 8'd0));
        send_request(mk(FUNC_WR_ALIVE, 6'd0, 6'd63, 1'b1, 8'd0));
        send_request(mk(FUNC_WR_ALIVE, 6'd1, 6'd63, 1'b1, 8'd0));
        send_request(mk(FUNC_ADVANCE, 6'd0, 6'd0, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd1, 6'd62, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd0, 6'd63, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd63, 6'd63, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd0, 6'd0, 1'b0, 8'd0));
    endtask

    task automatic test_rule_extremes();
        set_rules(9'd0, 9'd0, 9'd0);
        send_request(mk(FUNC_ADVANCE, 6'd0, 6'd0, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd0, 6'd63, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd1, 6'd62, 1'b0, 8'd0));
        set_rules(9'h1FF, 9'h1FF, 9'h1FF);
        write_register(CFG_SPARE, 9'h000);
        send_request(mk(FUNC_ADVANCE, 6'd0, 6'd0, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd32, 6'd32, 1'b0, 8'd0));
        write_register(CFG_SPARE, 9'h1FF);
        set_rules(9'd0, 9'd0, 9'd1);
        send_request(mk(FUNC_ADVANCE, 6'd0, 6'd0, 1'b0, 8'd0));
        send_request(mk(FUNC_ADVANCE, 6'd0, 6'd0, 1'b0, 8'd0));
        send_request(mk(FUNC_READ, 6'd63, 6'd63, 1'b0, 8'd0));
    endtask

    task automatic test_random_phase(input int target, input bit steady, input bit hold_off);
        int sent;
        int n;
        logic [5:0] cr;
        logic [5:0] cc;
        logic [2:0] spare;
        sent = 0;
        no_gaps = steady;
        while (sent < target)
        begin
            cr = pick_center();
            cc = pick_center();
            n = $urandom_range(2, 6);
            repeat (n)
            begin
                send_request(mk(FUNC_WR_ALIVE, near(cr), near(cc), $urandom_range(0, 99) < 75,
                                8'($urandom)));
            end
            sent += n;
            n = $urandom_range(0, 2);
            repeat (n)
            begin
                send_request(mk(FUNC_WR_AGE, near(cr), near(cc), 1'($urandom), 8'($urandom)));
            end
            sent += n;
            if ($urandom_range(0, 99) < 80)
            begin
                send_request(mk(FUNC_ADVANCE, 6'($urandom), 6'($urandom), 1'($urandom),
                                8'($urandom)));
                sent++;
            end
            n = $urandom_range(2, 4);
            repeat (n)
            begin
                send_request(mk(FUNC_READ, near(cr), near(cc), 1'($urandom), 8'($urandom)));
            end
            sent += n;
            if ($urandom_range(0, 99) < 15)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        spare = 3'($urandom_range(int'(FUNC_SPARE_A), int'(FUNC_SPARE_C)));
                        send_request(mk(spare, 6'($urandom), 6'($urandom), 1'($urandom),
                                        8'($urandom)));
                        sent++;
                    end
                    1:
                    begin
                        send_request(mk(FUNC_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom),
                                        8'($urandom)));
                        sent++;
                    end
                    default:
                    begin
                        send_request(mk(FUNC_READ, 6'($urandom), 6'($urandom), 1'($urandom),
                                        8'($urandom)));
                        sent++;
                    end
                endcase
            end
            if (hold_off && sent >= target / 2)
            begin
                wait_idle();
                hold_off = 1'b0;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_WR_ALIVE;
        row = '0;
        col = '0;
        new_alive = 1'b0;
        new_age = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BIRTH;
        cfg_data = '0;
        birth_rule = BIRTH_RESET;
        survive_rule = SURVIVE_RESET;
        age_limit = MAX_AGE_RESET;
        foreach (grid_alive[i])
        begin
            grid_alive[i] = 1'b0;
            grid_age[i] = 8'd0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_writes_and_spare_codes();
        test_clear_keeps_ages();
        test_edge_generation();
        test_rule_extremes();

        set_rules(9'($urandom), 9'($urandom), 9'($urandom_range(1, 255)));
        test_random_phase(25, 1'b0, 1'b0);
        set_rules(BIRTH_RESET, SURVIVE_RESET, 9'd3);
        test_random_phase(25, 1'b1, 1'b0);
        set_rules(9'd0, 9'h1FF, 9'd255);
        test_random_phase(25, 1'b0, 1'b1);
        set_rules(9'($urandom) & 9'h1FE, 9'($urandom), 9'($urandom));
        test_random_phase(25, 1'b0, 1'b0);

        wait_idle();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/llaa_pkg.sv
rtl/core/llaa_ram.sv
rtl/core/llaa_window.sv
rtl/core/life_like_automaton_with_aging_core.sv
rtl/core/llaa_checker.sv
test/tb.sv
